[rtl/weighted_histogram_binner_core_macros.svh]
// Assertion macros shared by the histogram binner RTL.
`ifndef WEIGHTED_HISTOGRAM_BINNER_CORE_MACROS_SVH
`define WEIGHTED_HISTOGRAM_BINNER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define WHB_ASSERT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked outside reset.
`define WHB_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define WHB_ASSERT(name, clk, rst, ante, cons, msg)
`define WHB_ASSERT_NEXT(name, clk, rst, ante, cons, msg)
`endif

`endif

[rtl/whb_pkg.sv]
package whb_pkg;

  localparam int MAX_BINS    = 64;
  localparam int COUNT_WIDTH = 48;
  localparam int BIN_W       = $clog2(MAX_BINS);
  localparam int NB_W        = 7;                    // bins_in_use field width
  localparam int QUOT_W      = $clog2(MAX_BINS + 1); // quotient never exceeds MAX_BINS
  localparam int SPAN_W      = 32;
  localparam int PROD_W      = SPAN_W + QUOT_W;
  localparam int STEP_W      = $clog2(QUOT_W);
  localparam int WEIGHT_W    = 16;
  localparam int ADDR_W      = 4;
  localparam int REG_IDX_W   = 2;

  localparam logic [NB_W-1:0] DEFAULT_BINS = NB_W'(20);

  localparam logic [REG_IDX_W-1:0] REG_RANGE_LOW  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_RANGE_HIGH = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_BINS       = 2'd2;

  localparam logic REQ_ADD  = 1'b0;
  localparam logic REQ_DUMP = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_RD,
    ST_WR,
    ST_DUMP
  } state_t;

  typedef struct packed {
    logic                   rd_en;
    logic [BIN_W-1:0]       rd_addr;
    logic                   wr_en;
    logic [BIN_W-1:0]       wr_addr;
    logic [COUNT_WIDTH-1:0] wr_data;
  } store_req_t;

endpackage

[rtl/whb_divider.sv]
// Restoring divider, one quotient bit per cycle.
// Expects dividend < divisor * 2**QUOT_W, so the top slice starts below the divisor.
module whb_divider import whb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [PROD_W-1:0] dividend,
  input  logic [SPAN_W-1:0] divisor,
  output logic              done,
  output logic [QUOT_W-1:0] quotient
);

  logic [SPAN_W-1:0] rem;
  logic [QUOT_W-1:0] lowbits;
  logic [STEP_W-1:0] cnt;
  logic              running;

  logic [SPAN_W:0]   trial;
  logic [SPAN_W:0]   diff;
  logic              ge;
  logic [SPAN_W-1:0] rem_next;

  always_comb begin
    trial    = {rem, lowbits[QUOT_W-1]};
    ge       = trial >= {1'b0, divisor};
    diff     = trial - {1'b0, divisor};
    rem_next = ge ? diff[SPAN_W-1:0] : trial[SPAN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
      end else if (running && cnt == STEP_W'(QUOT_W - 1)) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= dividend[PROD_W-1:QUOT_W];
      lowbits <= dividend[QUOT_W-1:0];
      cnt     <= '0;
    end else if (running) begin
      rem      <= rem_next;
      lowbits  <= {lowbits[QUOT_W-2:0], 1'b0};
      quotient <= {quotient[QUOT_W-2:0], ge};
      cnt      <= cnt + STEP_W'(1);
    end
  end

endmodule

[rtl/whb_bin_store.sv]
// Bin counter memory with per-entry valid bits; an unwritten entry reads zero.
module whb_bin_store import whb_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  store_req_t             req,
  output logic [COUNT_WIDTH-1:0] rd_data
);

  logic [COUNT_WIDTH-1:0] mem [MAX_BINS];
  logic [MAX_BINS-1:0]    valid;
  logic [COUNT_WIDTH-1:0] mem_q;
  logic                   hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (req.wr_en) begin
      valid[req.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      mem_q <= mem[req.rd_addr];
      hit   <= valid[req.rd_addr];
    end
  end

  assign rd_data = hit ? mem_q : '0;

endmodule

[rtl/weighted_histogram_binner_core.sv]
// Channel  | Direction | Ports                                           | Handshake
// command  | in        | req_type, sample_value, sample_weight           | start & !busy
// result   | out       | bin_number, bin_total, last_bin                 | result_valid strobe
// config   | in        | psel, penable, pwrite, paddr, pwdata, prdata    | APB, pready tied high
//
// Add word in range: busy through one multiply, QUOT_W = 7 restoring divide
// steps on the divider's subtractor and its done strobe, one memory read, one write.
// Zero span skips the divide. A sample out of range is dropped at once.
// Dump word: reads one bin per cycle for each bin in use; each result comes the cycle after its read.
// Synchronous active-high reset clears the FSM, strobes and all bin valid bits.
// The receiver cannot stall: result_valid is a one-cycle strobe.
`include "weighted_histogram_binner_core_macros.svh"

module weighted_histogram_binner_core import whb_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  // command
  input  logic                   start,
  output logic                   busy,
  input  logic                   req_type,
  input  logic signed [31:0]     sample_value,
  input  logic [WEIGHT_W-1:0]    sample_weight,
  // result
  output logic                   result_valid,
  output logic [5:0]             bin_number,
  output logic [47:0]            bin_total,
  output logic                   last_bin,
  // config
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_W-1:0]      paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic signed [31:0] range_low;
  logic signed [31:0] range_high;
  logic [NB_W-1:0]    bins_in_use;
  logic [REG_IDX_W-1:0] reg_idx;
  logic               cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_low   <= '0;
      range_high  <= '0;
      bins_in_use <= DEFAULT_BINS;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_RANGE_LOW:  range_low   <= pwdata;
        REG_RANGE_HIGH: range_high  <= pwdata;
        REG_BINS:       bins_in_use <= pwdata[NB_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_RANGE_LOW:  prdata = range_low;
      REG_RANGE_HIGH: prdata = range_high;
      REG_BINS:       prdata = 32'(bins_in_use);
      default:        prdata = '0;
    endcase
  end

  // Effective bin count: 0 acts as 1, anything past MAX_BINS clamps.
  logic [NB_W-1:0] nb;
  always_comb begin
    if (bins_in_use == '0)
      nb = NB_W'(1);
    else if (bins_in_use > NB_W'(MAX_BINS))
      nb = NB_W'(MAX_BINS);
    else
      nb = bins_in_use;
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  state_t state, state_next;

  logic              accept;
  logic              in_range;
  logic [SPAN_W-1:0] offset;     // sample - low, fits since sample in [low, high]
  logic [SPAN_W-1:0] span;
  logic              zero_span;
  logic [WEIGHT_W-1:0] weight;
  logic [BIN_W-1:0]  idx;        // dump read pointer
  logic              dump_last;

  logic              out_v;
  logic [BIN_W-1:0]  out_idx;
  logic              out_last;

  logic              div_start;
  logic              div_done;
  logic [QUOT_W-1:0] quotient;
  logic [PROD_W-1:0] product;
  logic [BIN_W-1:0]  bin_sel;

  logic [COUNT_WIDTH:0]   sum;
  logic [COUNT_WIDTH-1:0] sat_sum;
  logic [COUNT_WIDTH-1:0] rd_data;
  store_req_t             store_req;

  assign accept    = start && !busy;
  assign in_range  = (sample_value >= range_low) && (sample_value <= range_high);
  assign dump_last = {1'b0, idx} == (nb - NB_W'(1));

  // Operand widening for the one multiply: offset (32 b) times bin count (7 b).
  assign product = PROD_W'(offset) * PROD_W'(nb);

  // Clamp the quotient to the last bin in use; a zero span maps to bin 0.
  always_comb begin
    if (zero_span)
      bin_sel = '0;
    else if (quotient >= QUOT_W'(nb))
      bin_sel = BIN_W'(nb - NB_W'(1));
    else
      bin_sel = quotient[BIN_W-1:0];
  end

  // Saturating accumulate of the weight onto the count read back.
  assign sum     = {1'b0, rd_data} + (COUNT_WIDTH + 1)'(weight);
  assign sat_sum = sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (req_type == REQ_DUMP)
            state_next = ST_DUMP;
          else if (in_range)
            state_next = ST_MUL;
        end
      end
      ST_MUL:  state_next = zero_span ? ST_RD : ST_DIV;
      ST_DIV:  state_next = div_done ? ST_RD : ST_DIV;
      ST_RD:   state_next = ST_WR;
      ST_WR:   state_next = ST_IDLE;
      ST_DUMP: state_next = dump_last ? ST_IDLE : ST_DUMP;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    busy              = state != ST_IDLE;
    div_start         = (state == ST_MUL) && !zero_span;
    store_req.rd_en   = (state == ST_RD) || (state == ST_DUMP);
    store_req.rd_addr = (state == ST_DUMP) ? idx : bin_sel;
    store_req.wr_en   = state == ST_WR;
    store_req.wr_addr = bin_sel;
    store_req.wr_data = sat_sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_v <= 1'b0;
    end else begin
      state <= state_next;
      out_v <= state == ST_DUMP;
    end
  end

  // operand capture and dump pointer
  always_ff @(posedge clk) begin
    if (accept) begin
      offset    <= sample_value - range_low;
      span      <= range_high - range_low;
      zero_span <= range_high == range_low;
      weight    <= sample_weight;
      idx       <= '0;
    end else if (state == ST_DUMP) begin
      idx <= idx + BIN_W'(1);
    end
    out_idx  <= idx;
    out_last <= dump_last;
  end

  whb_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (product),
    .divisor  (span),
    .done     (div_done),
    .quotient (quotient)
  );

  whb_bin_store u_store (
    .clk     (clk),
    .rst     (rst),
    .req     (store_req),
    .rd_data (rd_data)
  );

  // Result word: memory read data lines up with the delayed dump index.
  assign result_valid = out_v;
  assign bin_number   = out_idx;
  assign bin_total    = rd_data;
  assign last_bin     = out_v && out_last;

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  `WHB_ASSERT_NEXT(a_dump_strobe, clk, rst, state == ST_DUMP, result_valid, "dump read without result")
  `WHB_ASSERT(a_result_in_range, clk, rst, result_valid, {1'b0, bin_number} < nb, "bin past count")
  `WHB_ASSERT(a_write_after_read, clk, rst, state == ST_WR, $past(state) == ST_RD, "write w/o read")
  `WHB_ASSERT(a_div_quiet, clk, rst, div_done, state == ST_DIV, "divider done outside divide")

endmodule
